FILE: hw/rtl/fraction_canonicalizer_macros.svh
// Assertion macros shared by the fraction canonicalizer checker.
// No dependencies.
`ifndef FRACTION_CANONICALIZER_MACROS_SVH
`define FRACTION_CANONICALIZER_MACROS_SVH

// Concurrent check, disabled while reset is high.
`define FC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define FC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/fc_pkg.sv
// Types and constants for the fraction canonicalizer.
// No dependencies; imported by every module of the block.
package fc_pkg;

   localparam int IN_BITS  = 64;
   localparam int DEN_BITS = 63;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_NOT_REPR = 2'd2;

   typedef struct packed {
      logic signed [IN_BITS-1:0] numerator_in;
      logic signed [IN_BITS-1:0] denominator_in;
   } req_type;

   typedef struct packed {
      logic signed [IN_BITS-1:0] reduced_numerator;
      logic [DEN_BITS-1:0]       reduced_denominator;
      logic [1:0]                status;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GCD,
      S_DIV_NUM,
      S_DIV_DEN
   } state_type;

   typedef struct packed {
      logic load;
      logic gcd_step;
      logic div_load;
      logic div_den;
      logic div_step;
      logic save_num;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic gcd_done;
      logic div_done;
   } sts_type;

endpackage

FILE: hw/rtl/fc_datapath.sv
// Datapath: input decode, binary GCD unit, shared serial divider, result register.
// Depends on fc_pkg.
module fc_datapath import fc_pkg::*; #(
   parameter int WORD_BITS = 64
) (
   input  logic    clock,
   input  req_type req_item,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_item
);

   localparam int KW = $clog2(WORD_BITS);
   localparam int CW = $clog2(WORD_BITS + 1);

   typedef logic [WORD_BITS-1:0] word_type;

   localparam word_type SIGN_WORD = word_type'(1) << (WORD_BITS - 1);

   word_type n, d, nm, dm;
   logic     sp_in;
   logic [1:0] sp_st_in;
   word_type sp_n_in;
   logic     sp_d_in;

   logic       special_ff;
   logic [1:0] sp_st_ff;
   word_type   sp_n_ff;
   logic       sp_d_ff;
   logic       neg_ff;
   word_type   nm_ff, dm_ff;
   word_type   a_ff, b_ff;
   logic [KW-1:0] k_ff;
   word_type   divisor_ff, rem_ff, quo_ff, qn_ff;
   logic [CW-1:0] cnt_ff;
   rsp_type    rsp_ff;

   logic [WORD_BITS:0] diff_ab;
   logic [WORD_BITS:0] rem_sh, trial;
   word_type   qn_signed;

   assign n  = req_item.numerator_in[WORD_BITS-1:0];
   assign d  = req_item.denominator_in[WORD_BITS-1:0];
   assign nm = n[WORD_BITS-1] ? (~n + word_type'(1)) : n;
   assign dm = d[WORD_BITS-1] ? (~d + word_type'(1)) : d;

   always_comb begin
      sp_in    = 1'b1;
      sp_st_in = STATUS_OK;
      sp_n_in  = '0;
      sp_d_in  = 1'b0;
      if (d == '0) begin
         sp_st_in = STATUS_ZERO_DEN;
      end else if ((n == SIGN_WORD && d[0]) || (d == SIGN_WORD && n[0])) begin
         sp_st_in = STATUS_NOT_REPR;
      end else if (n == '0) begin
         sp_d_in = 1'b1;
      end else if (n == d) begin
         sp_n_in = word_type'(1);
         sp_d_in = 1'b1;
      end else if (nm == dm && n[WORD_BITS-1] != d[WORD_BITS-1]) begin
         sp_n_in = '1;
         sp_d_in = 1'b1;
      end else begin
         sp_in = 1'b0;
      end
   end

   assign diff_ab = {1'b0, a_ff} - {1'b0, b_ff};
   assign rem_sh  = {rem_ff, quo_ff[WORD_BITS-1]};
   assign trial   = rem_sh - {1'b0, divisor_ff};
   assign qn_signed = neg_ff ? (~qn_ff + word_type'(1)) : qn_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         special_ff <= sp_in;
         sp_st_ff   <= sp_st_in;
         sp_n_ff    <= sp_n_in;
         sp_d_ff    <= sp_d_in;
         neg_ff     <= n[WORD_BITS-1] ^ d[WORD_BITS-1];
         nm_ff      <= nm;
         dm_ff      <= dm;
         a_ff       <= nm;
         b_ff       <= dm;
         k_ff       <= '0;
      end else if (cmd.gcd_step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_ff <= a_ff >> 1;
            b_ff <= b_ff >> 1;
            k_ff <= k_ff + KW'(1);
         end else if (!a_ff[0]) begin
            a_ff <= a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_ff <= b_ff >> 1;
         end else if (!diff_ab[WORD_BITS]) begin
            a_ff <= diff_ab[WORD_BITS-1:0];
         end else begin
            b_ff <= b_ff - a_ff;
         end
      end

      if (cmd.div_load) begin
         divisor_ff <= a_ff << k_ff;
         rem_ff     <= '0;
         quo_ff     <= cmd.div_den ? dm_ff : nm_ff;
         cnt_ff     <= '0;
      end else if (cmd.div_step) begin
         if (!trial[WORD_BITS]) begin
            rem_ff <= trial[WORD_BITS-1:0];
         end else begin
            rem_ff <= rem_sh[WORD_BITS-1:0];
         end
         quo_ff <= {quo_ff[WORD_BITS-2:0], ~trial[WORD_BITS]};
         cnt_ff <= cnt_ff + CW'(1);
      end

      if (cmd.save_num) begin
         qn_ff <= quo_ff;
      end

      if (cmd.respond) begin
         if (special_ff) begin
            rsp_ff.reduced_numerator   <= IN_BITS'(signed'(sp_n_ff));
            rsp_ff.reduced_denominator <= DEN_BITS'(sp_d_ff);
            rsp_ff.status              <= sp_st_ff;
         end else begin
            rsp_ff.reduced_numerator   <= IN_BITS'(signed'(qn_signed));
            rsp_ff.reduced_denominator <= DEN_BITS'(quo_ff);
            rsp_ff.status              <= STATUS_OK;
         end
      end
   end

   assign sts.special  = special_ff;
   assign sts.gcd_done = (a_ff == b_ff);
   assign sts.div_done = (cnt_ff == CW'(WORD_BITS));
   assign rsp_item     = rsp_ff;

endmodule

FILE: hw/rtl/fc_controller.sv
// Controller: sequences load, GCD, the two divisions and the result strobe.
// Depends on fc_pkg.
module fc_controller import fc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output logic    busy,
   output cmd_type cmd,
   output logic    rsp_valid
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_GCD;
         end
         S_GCD: begin
            if (sts.special) state_in = S_IDLE;
            else if (sts.gcd_done) state_in = S_DIV_NUM;
         end
         S_DIV_NUM: begin
            if (sts.div_done) state_in = S_DIV_DEN;
         end
         S_DIV_DEN: begin
            if (sts.div_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = start;
         end
         S_GCD: begin
            if (sts.special) begin
               cmd.respond = 1'b1;
            end else if (sts.gcd_done) begin
               cmd.div_load = 1'b1;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV_NUM: begin
            if (sts.div_done) begin
               cmd.save_num = 1'b1;
               cmd.div_load = 1'b1;
               cmd.div_den  = 1'b1;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_DIV_DEN: begin
            if (sts.div_done) begin
               cmd.respond = 1'b1;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/fraction_canonicalizer.sv
// Fraction canonicalizer top level: controller plus datapath.
// Depends on fc_pkg, fc_controller, fc_datapath.
//
//   channel   ports                      handshake
//   request   start, busy, req_item      taken when start && !busy
//   response  rsp_valid, rsp_item        one-cycle strobe, no backpressure
//
// Per transaction: load, then one binary GCD step (a shift or a subtract) per cycle until
// the operands meet, then a divider load, then two restoring divisions (numerator, then
// denominator) on the shared divider; the registered result strobe follows in the next cycle.
// Special cases (errors, zero, +/-1) skip the GCD and the divisions and respond from the
// GCD state.
// Synchronous active-high reset returns the controller to idle.
// busy drops in the cycle rsp_valid is shown; a new request may then start.
module fraction_canonicalizer import fc_pkg::*; #(
   parameter int WORD_BITS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   cmd_type cmd;
   sts_type sts;

   fc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   fc_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock    (clock),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule

FILE: hw/rtl/fc_checker.sv
// Port-level checks for the fraction canonicalizer, bound to the top level.
// Depends on fc_pkg and fraction_canonicalizer_macros.svh.
`include "fraction_canonicalizer_macros.svh"

module fc_checker import fc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   logic err_rsp;
   logic ok_rsp;
   logic err_zero;
   logic ok_den;

   assign err_rsp  = rsp_valid && (rsp_item.status != STATUS_OK);
   assign ok_rsp   = rsp_valid && (rsp_item.status == STATUS_OK);
   assign err_zero = (rsp_item.reduced_numerator == '0) &&
                     (rsp_item.reduced_denominator == '0);
   assign ok_den   = (rsp_item.reduced_denominator != '0);

   `FC_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accepted request not busy")
   `FC_ASSERT(a_done_strobe, clock, reset, $fell(busy) |-> rsp_valid, "busy fell without result")
   `FC_ASSERT(a_single_rsp, clock, reset, rsp_valid |=> !rsp_valid, "result repeated")
   `FC_ASSERT(a_err_zero, clock, reset, err_rsp |-> err_zero, "error result not zero")
   `FC_ASSERT(a_ok_den, clock, reset, ok_rsp |-> ok_den, "zero denominator on ok result")

endmodule

bind fraction_canonicalizer fc_checker u_fc_checker (.*);
